>>> hdl/gdpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpg_pkg
// Shared types and constants of the Gaussian dispersion point generator.
// ----------------------------------------------------------------------------
package gdpg_pkg;

    // Default largest number of points in one run.
    localparam int MAX_POINTS_DEF = 64;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAUSSIAN_MODE = 3'd0;
    localparam logic [2:0] REG_POINT_COUNT   = 3'd1;
    localparam logic [2:0] REG_SIGMA_SPAN    = 3'd2;
    localparam logic [2:0] REG_SPREAD_WIDTH  = 3'd3;
    localparam logic [2:0] REG_BOUND_ENABLE  = 3'd4;
    localparam logic [2:0] REG_LOWER_BOUND   = 3'd5;
    localparam logic [2:0] REG_UPPER_BOUND   = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Width of the shared divider's dividend and quotient.
    localparam int DIVD_W = 64;

    // Number of Taylor series terms for exp(-F).
    localparam logic [4:0] TAYLOR_TERMS = 5'd20;

    // Index of the last squaring after the series, counted from zero.
    localparam logic [1:0] SQUARINGS_LAST = 2'd3;

    // Weight of 1.0 in Q1.15.
    localparam logic [15:0] WEIGHT_ONE = 16'h8000;

    // Configuration the point sequencer works from.
    typedef struct packed {
        logic               gaussian_mode;
        logic [3:0]         sigma_span;
        logic [30:0]        spread_width;
        logic [1:0]         bound_enable;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
    } t_cfg;

endpackage

>>> hdl/gdpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpg_front
// Accepts center values, works out the run length and keeps a two-entry
// queue of runs for the point sequencer.
// ----------------------------------------------------------------------------
module gdpg_front
    import gdpg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            i_center_value,
    input  logic [6:0]                    i_point_count,
    output logic                          o_job_valid,
    input  logic                          i_job_take,
    output logic signed [31:0]            o_job_center,
    output logic [$clog2(MAX_POINTS)-1:0] o_job_last
);

    localparam int IW = $clog2(MAX_POINTS);

    logic signed [31:0] r_center [2];
    logic [IW-1:0]      r_last   [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    logic [9:0]    cnt_ext;
    logic [9:0]    n_eff;
    logic [IW-1:0] last_idx;
    logic          do_push;
    logic          do_pop;

    // Clamp the point count to 1..MAX_POINTS; the run's last index is n-1.
    always_comb begin
        cnt_ext = {3'b000, i_point_count};
        if (cnt_ext == 10'd0) begin
            n_eff = 10'd1;
        end else if (cnt_ext > 10'(MAX_POINTS)) begin
            n_eff = 10'(MAX_POINTS);
        end else begin
            n_eff = cnt_ext;
        end
        last_idx = IW'(n_eff - 10'd1);
    end

    assign full         = (r_count == 2'd2);
    assign o_job_valid  = (r_count != 2'd0);
    assign o_job_center = r_center[r_rd_ptr];
    assign o_job_last   = r_last[r_rd_ptr];
    assign do_push      = push && !full;
    assign do_pop       = i_job_take && o_job_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_center[r_wr_ptr] <= i_center_value;
            r_last[r_wr_ptr]   <= last_idx;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> hdl/gdpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpg_div
// Restoring divider, one quotient bit per cycle, shared by the offset,
// exponent argument and series term divisions.
// ----------------------------------------------------------------------------
module gdpg_div
    import gdpg_pkg::*;
#(
    parameter int DVW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DVW-1:0]    i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DVW-1:0]    r_rem;
    logic [DVW-1:0]    r_dsr;
    logic [DIVD_W-1:0] r_quo;

    logic [DVW:0] trial;
    logic [DVW:0] diff;
    logic         fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], fits};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/gdpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpg_back
// Point sequencer: walks the points of one run, forms each offset, the weight
// (Gaussian or 1.0) and the flags, and holds the result item for the reader.
// ----------------------------------------------------------------------------
module gdpg_back
    import gdpg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_job_valid,
    output logic                          o_job_take,
    input  logic signed [31:0]            i_job_center,
    input  logic [$clog2(MAX_POINTS)-1:0] i_job_last,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            o_point_value,
    output logic [15:0]                   o_point_weight,
    output logic                          o_in_range,
    output logic                          o_saturated,
    output logic                          o_last_point
);

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int KW    = IW + 2;
    localparam int SKW   = IW + 4;
    localparam int MAG_W = SKW + 31;
    localparam int VAL_W = MAG_W + 2;
    localparam int AW    = 2 * SKW;
    localparam int DDW   = 2 * IW;
    localparam int DVW   = 2 * IW + 5;

    typedef enum logic [3:0] {
        S_IDLE, S_PT, S_MUL, S_ODIV, S_OWAIT, S_WCHK, S_FWAIT,
        S_TMUL, S_TDIV, S_TWAIT, S_SQMUL, S_SQACC, S_WFIN, S_EMIT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_center;
    logic [IW-1:0]      r_d;
    logic [IW-1:0]      r_idx;
    logic               r_single;
    logic               r_kneg;
    logic [IW-1:0]      r_ak;
    logic [SKW-1:0]     r_sk;
    logic [MAG_W-1:0]   r_mag;
    logic [AW-1:0]      r_a;
    logic [DDW-1:0]     r_dd;
    logic [VAL_W-1:0]   r_val;
    logic [30:0]        r_f;
    logic [31:0]        r_term;
    logic signed [33:0] r_sum;
    logic [4:0]         r_j;
    logic [31:0]        r_v;
    logic [1:0]         r_sq;
    logic [DIVD_W-1:0]  r_prod;
    logic [15:0]        r_weight;

    logic               r_div_start;
    logic [DIVD_W-1:0]  r_div_dividend;
    logic [DVW-1:0]     r_div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_q;

    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [15:0]        r_out_weight;
    logic               r_out_in_range;
    logic               r_out_sat;
    logic               r_out_last;

    logic signed [KW-1:0] k_w;
    logic [KW-1:0]        k_mag;
    logic [IW:0]          off_den;
    logic [MAG_W:0]       q_off;
    logic [VAL_W-1:0]     off_s;
    logic [VAL_W-1:0]     center_ext;
    logic [AW-1:0]        twelve_b;
    logic [31:0]          term_next;
    logic [31:0]          v_clamp;
    logic [31:0]          w_round;
    logic                 sat_pos;
    logic                 sat_neg;
    logic [VAL_W-1:0]     lo_ext;
    logic [VAL_W-1:0]     hi_ext;
    logic                 lo_ok;
    logic                 hi_ok;
    logic                 slot_free;
    logic                 emit_now;

    gdpg_div #(
        .DVW(DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dividend),
        .i_divisor  (r_div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Grid position of the current point, k = 2i - (n-1), and its magnitude.
    always_comb begin
        k_w   = $signed({1'b0, r_idx, 1'b0}) - $signed({2'b00, r_d});
        k_mag = k_w[KW-1] ? KW'(-k_w) : KW'(k_w);
    end

    // Offset divisor: n-1 for the Gaussian grid, 2(n-1) for the uniform grid.
    always_comb begin
        off_den    = i_cfg.gaussian_mode ? {1'b0, r_d} : {r_d, 1'b0};
        q_off      = div_q[MAG_W:0];
        off_s      = r_kneg ? VAL_W'(-{1'b0, q_off}) : VAL_W'({1'b0, q_off});
        center_ext = {{(VAL_W-32){r_center[31]}}, r_center};
        twelve_b   = AW'({r_dd, 4'b0000}) + AW'({r_dd, 3'b000});
    end

    // Series term rounding, sum clamping and final weight rounding.
    always_comb begin
        term_next = 32'((div_q + DIVD_W'(64'h4000_0000)) >> 31);
        if (r_sum[33]) begin
            v_clamp = 32'd0;
        end else if (r_sum > 34'sh0_8000_0000) begin
            v_clamp = 32'h8000_0000;
        end else begin
            v_clamp = r_sum[31:0];
        end
        w_round = (r_v + 32'h0000_8000) >> 16;
    end

    // Saturation and bound checks on the exact point value.
    always_comb begin
        sat_pos = !r_val[VAL_W-1] && (|r_val[VAL_W-2:31]);
        sat_neg = r_val[VAL_W-1] && !(&r_val[VAL_W-2:31]);
        lo_ext  = {{(VAL_W-32){i_cfg.lower_bound[31]}}, i_cfg.lower_bound};
        hi_ext  = {{(VAL_W-32){i_cfg.upper_bound[31]}}, i_cfg.upper_bound};
        lo_ok   = !i_cfg.bound_enable[0] || ($signed(r_val) > $signed(lo_ext));
        hi_ok   = !i_cfg.bound_enable[1] || ($signed(r_val) < $signed(hi_ext));
    end

    assign slot_free  = !r_out_valid || pop;
    assign emit_now   = (r_state == S_EMIT) && slot_free;
    assign o_job_take = (r_state == S_IDLE);

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (pop && r_out_valid && !emit_now) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_center <= i_job_center;
                        r_d      <= i_job_last;
                        r_idx    <= '0;
                        if (i_cfg.spread_width == 31'd0 || i_job_last == '0) begin
                            r_single <= 1'b1;
                            r_val    <= {{(VAL_W-32){i_job_center[31]}}, i_job_center};
                            r_weight <= WEIGHT_ONE;
                            r_state  <= S_EMIT;
                        end else begin
                            r_single <= 1'b0;
                            r_state  <= S_PT;
                        end
                    end
                end
                S_PT: begin
                    r_kneg  <= k_w[KW-1];
                    r_ak    <= IW'(k_mag);
                    r_sk    <= SKW'(i_cfg.sigma_span) * SKW'(k_mag);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (i_cfg.gaussian_mode) begin
                        r_mag <= MAG_W'(i_cfg.spread_width) * MAG_W'(r_sk);
                    end else begin
                        r_mag <= MAG_W'(i_cfg.spread_width) * MAG_W'(r_ak);
                    end
                    r_a     <= AW'(r_sk) * AW'(r_sk);
                    r_dd    <= DDW'(r_d) * DDW'(r_d);
                    r_state <= S_ODIV;
                end
                S_ODIV: begin
                    r_div_start    <= 1'b1;
                    r_div_dividend <= DIVD_W'({r_mag, 1'b0}) + DIVD_W'(off_den);
                    r_div_divisor  <= DVW'({off_den, 1'b0});
                    r_state        <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (div_done) begin
                        r_val <= center_ext + off_s;
                        if (i_cfg.gaussian_mode) begin
                            r_state <= S_WCHK;
                        end else begin
                            r_weight <= WEIGHT_ONE;
                            r_state  <= S_EMIT;
                        end
                    end
                end
                S_WCHK: begin
                    if (r_a >= twelve_b) begin
                        r_weight <= 16'd0;
                        r_state  <= S_EMIT;
                    end else begin
                        r_div_start    <= 1'b1;
                        r_div_dividend <= (DIVD_W'(r_a) << 31) + DIVD_W'({r_dd, 4'b0000});
                        r_div_divisor  <= DVW'({r_dd, 5'b00000});
                        r_state        <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    if (div_done) begin
                        r_f     <= div_q[30:0];
                        r_term  <= 32'h8000_0000;
                        r_sum   <= 34'sh0_8000_0000;
                        r_j     <= 5'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    if (r_j > TAYLOR_TERMS || r_term == 32'd0) begin
                        r_v     <= v_clamp;
                        r_sq    <= 2'd0;
                        r_state <= S_SQMUL;
                    end else begin
                        r_prod  <= DIVD_W'(r_term) * DIVD_W'(r_f);
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    r_div_start    <= 1'b1;
                    r_div_dividend <= r_prod;
                    r_div_divisor  <= DVW'(r_j);
                    r_state        <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (div_done) begin
                        r_term <= term_next;
                        if (r_j[0]) begin
                            r_sum <= r_sum - $signed({2'b00, term_next});
                        end else begin
                            r_sum <= r_sum + $signed({2'b00, term_next});
                        end
                        r_j     <= r_j + 5'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_SQMUL: begin
                    r_prod  <= DIVD_W'(r_v) * DIVD_W'(r_v);
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    r_v  <= 32'((r_prod + DIVD_W'(64'h4000_0000)) >> 31);
                    r_sq <= r_sq + 2'd1;
                    if (r_sq == SQUARINGS_LAST) begin
                        r_state <= S_WFIN;
                    end else begin
                        r_state <= S_SQMUL;
                    end
                end
                S_WFIN: begin
                    if (w_round > 32'(WEIGHT_ONE)) begin
                        r_weight <= WEIGHT_ONE;
                    end else begin
                        r_weight <= w_round[15:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_weight <= r_weight;
                        if (r_single) begin
                            r_out_value    <= r_center;
                            r_out_in_range <= 1'b1;
                            r_out_sat      <= 1'b0;
                            r_out_last     <= 1'b1;
                            r_state        <= S_IDLE;
                        end else begin
                            if (sat_pos) begin
                                r_out_value <= 32'sh7FFF_FFFF;
                            end else if (sat_neg) begin
                                r_out_value <= 32'sh8000_0000;
                            end else begin
                                r_out_value <= r_val[31:0];
                            end
                            r_out_in_range <= lo_ok && hi_ok;
                            r_out_sat      <= sat_pos || sat_neg;
                            r_out_last     <= (r_idx == r_d);
                            if (r_idx == r_d) begin
                                r_idx   <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_idx   <= r_idx + IW'(1);
                                r_state <= S_PT;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign empty          = !r_out_valid;
    assign o_point_value  = r_out_value;
    assign o_point_weight = r_out_weight;
    assign o_in_range     = r_out_in_range;
    assign o_saturated    = r_out_sat;
    assign o_last_point   = r_out_last;

`ifndef SYNTH
    // A saturated item always carries one of the two extreme values.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
        (r_out_value == 32'sh7FFF_FFFF || r_out_value == 32'sh8000_0000))
        else $error("saturated item without an extreme value");

    // The weight never exceeds 1.0.
    a_weight_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_weight <= WEIGHT_ONE))
        else $error("item weight above 1.0");

    // The divider only finishes while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |->
        (r_state == S_OWAIT || r_state == S_FWAIT || r_state == S_TWAIT))
        else $error("divider result arrived outside a wait state");

    // A new item is only loaded into a free result slot.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> r_out_valid)
        else $error("pending item lost");
`endif

endmodule

>>> hdl/gaussian_dispersion_point_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_dispersion_point_generator_top
// Gaussian-weighted sample grid: one center value in, a run of weighted
// grid points out, with configuration registers.
// ----------------------------------------------------------------------------
// Each accepted center value produces a run of point_count items, clamped to
// 1..MAX_POINTS (one item when the width is zero or the count is one). Points
// are produced one at a time by a sequencer around a single shared divider
// that retires one quotient bit per cycle. A uniform-grid point needs one
// offset division; a Gaussian-grid point may add the exponent argument
// division and a series loop through the divider for each Taylor series term
// used (at most 20). Up to two center values queue ahead of the sequencer,
// and one finished item is held on the result ports until it is popped.
// ----------------------------------------------------------------------------
module gaussian_dispersion_point_generator_top
    import gdpg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic signed [31:0]    i_center_value,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [31:0]    o_point_value,
    output logic [15:0]           o_point_weight,
    output logic                  o_in_range,
    output logic                  o_saturated,
    output logic                  o_last_point,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_POINTS);

    t_cfg       r_cfg;
    logic [6:0] r_point_count;

    logic               job_valid;
    logic               job_take;
    logic signed [31:0] job_center;
    logic [IW-1:0]      job_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gaussian_mode <= 1'b1;
            r_point_count       <= 7'd1;
            r_cfg.sigma_span    <= 4'd2;
            r_cfg.spread_width  <= 31'd0;
            r_cfg.bound_enable  <= 2'd0;
            r_cfg.lower_bound   <= 32'sd0;
            r_cfg.upper_bound   <= 32'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAUSSIAN_MODE: r_cfg.gaussian_mode <= i_cfg_data[0];
                REG_POINT_COUNT:   r_point_count       <= i_cfg_data[6:0];
                REG_SIGMA_SPAN:    r_cfg.sigma_span    <= i_cfg_data[3:0];
                REG_SPREAD_WIDTH:  r_cfg.spread_width  <= i_cfg_data[30:0];
                REG_BOUND_ENABLE:  r_cfg.bound_enable  <= i_cfg_data[1:0];
                REG_LOWER_BOUND:   r_cfg.lower_bound   <= $signed(i_cfg_data);
                REG_UPPER_BOUND:   r_cfg.upper_bound   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    gdpg_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_center_value (i_center_value),
        .i_point_count  (r_point_count),
        .o_job_valid    (job_valid),
        .i_job_take     (job_take),
        .o_job_center   (job_center),
        .o_job_last     (job_last)
    );

    gdpg_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job_valid    (job_valid),
        .o_job_take     (job_take),
        .i_job_center   (job_center),
        .i_job_last     (job_last),
        .empty          (empty),
        .pop            (pop),
        .o_point_value  (o_point_value),
        .o_point_weight (o_point_weight),
        .o_in_range     (o_in_range),
        .o_saturated    (o_saturated),
        .o_last_point   (o_last_point)
    );

endmodule
